/* design/qvr_pkg.sv */
package qvr_pkg;

    // Default field widths
    localparam int VecWidth     = 24;
    localparam int QuatFracBits = 14;

    // Rotation matrix is 3x3, row-major
    localparam int NumCoef = 9;
    localparam int NumAxis = 3;

    // Configuration register map
    localparam int CfgIdxWidth = 2;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_QUAT_W = 2'd0,
        CFG_QUAT_I = 2'd1,
        CFG_QUAT_J = 2'd2,
        CFG_QUAT_K = 2'd3
    } t_cfg_idx;

endpackage

/* design/qvr_vec_if.sv */
interface qvr_vec_if #(
    parameter int VEC_WIDTH = qvr_pkg::VecWidth
);
    logic                        valid;
    logic                        ready;
    logic signed [VEC_WIDTH-1:0] vec_x;
    logic signed [VEC_WIDTH-1:0] vec_y;
    logic signed [VEC_WIDTH-1:0] vec_z;
    logic                        last_in;

    modport source (output valid, vec_x, vec_y, vec_z, last_in, input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, last_in, output ready);
endinterface

/* design/qvr_rot_if.sv */
interface qvr_rot_if #(
    parameter int VEC_WIDTH = qvr_pkg::VecWidth
);
    logic                        valid;
    logic                        ready;
    logic signed [VEC_WIDTH-1:0] rot_x;
    logic signed [VEC_WIDTH-1:0] rot_y;
    logic signed [VEC_WIDTH-1:0] rot_z;
    logic                        last_out;

    modport source (output valid, rot_x, rot_y, rot_z, last_out, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, last_out, output ready);
endinterface

/* design/qvr_coef.sv */
module qvr_coef #(
    parameter int QUAT_FRAC_BITS = qvr_pkg::QuatFracBits
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [qvr_pkg::CfgIdxWidth-1:0]       i_cfg_idx,
    input  logic [QUAT_FRAC_BITS+1:0]             i_cfg_data,
    output logic signed [QUAT_FRAC_BITS+5:0]      o_coef [qvr_pkg::NumCoef]
);
    import qvr_pkg::*;

    localparam int QW = QUAT_FRAC_BITS + 2;   // quaternion register, Q2.F
    localparam int CW = QUAT_FRAC_BITS + 6;   // coefficient, Q6.F
    localparam int PW = 2 * QW;               // exact product
    localparam int SW = PW + 3;               // weighted sum plus rounding

    localparam logic signed [QW-1:0] QuatOne = QW'(1) << QUAT_FRAC_BITS;
    localparam logic signed [PW-1:0] PrdOne  = PW'(1) << (2 * QUAT_FRAC_BITS);
    localparam logic signed [CW-1:0] CoefOne = CW'(1) << QUAT_FRAC_BITS;
    localparam logic signed [SW-1:0] Half    = SW'(1) << (QUAT_FRAC_BITS - 1);

    logic signed [QW-1:0] r_qw, r_qi, r_qj, r_qk;
    logic signed [PW-1:0] r_ww, r_ii, r_jj, r_kk;
    logic signed [PW-1:0] r_wi, r_wj, r_wk, r_ij, r_ik, r_jk;
    logic signed [CW-1:0] r_coef [NumCoef];
    logic signed [CW-1:0] n_coef [NumCoef];

    function automatic logic signed [SW-1:0] ext(input logic signed [PW-1:0] p);
        return SW'(p);
    endfunction

    // Round half up from 2F to F fraction bits; magnitude stays within 16.0
    function automatic logic signed [CW-1:0] rnd(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] t;
        t = s + Half;
        return t[QUAT_FRAC_BITS +: CW];
    endfunction

    // Quaternion registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qw <= QuatOne;
            r_qi <= '0;
            r_qj <= '0;
            r_qk <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_QUAT_W: r_qw <= i_cfg_data;
                CFG_QUAT_I: r_qi <= i_cfg_data;
                CFG_QUAT_J: r_qj <= i_cfg_data;
                CFG_QUAT_K: r_qk <= i_cfg_data;
                default:    r_qw <= r_qw;
            endcase
        end
    end

    // Stage A: the ten pairwise products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ww <= PrdOne;
            r_ii <= '0;
            r_jj <= '0;
            r_kk <= '0;
            r_wi <= '0;
            r_wj <= '0;
            r_wk <= '0;
            r_ij <= '0;
            r_ik <= '0;
            r_jk <= '0;
        end else begin
            r_ww <= r_qw * r_qw;
            r_ii <= r_qi * r_qi;
            r_jj <= r_qj * r_qj;
            r_kk <= r_qk * r_qk;
            r_wi <= r_qw * r_qi;
            r_wj <= r_qw * r_qj;
            r_wk <= r_qw * r_qk;
            r_ij <= r_qi * r_qj;
            r_ik <= r_qi * r_qk;
            r_jk <= r_qj * r_qk;
        end
    end

    // Stage B: matrix coefficients
    always_comb begin
        n_coef[0] = rnd(ext(r_ww) + ext(r_ii) - ext(r_jj) - ext(r_kk));
        n_coef[1] = rnd((ext(r_ij) - ext(r_wk)) <<< 1);
        n_coef[2] = rnd((ext(r_wj) + ext(r_ik)) <<< 1);
        n_coef[3] = rnd((ext(r_wk) + ext(r_ij)) <<< 1);
        n_coef[4] = rnd(ext(r_ww) - ext(r_ii) + ext(r_jj) - ext(r_kk));
        n_coef[5] = rnd((ext(r_jk) - ext(r_wi)) <<< 1);
        n_coef[6] = rnd((ext(r_ik) - ext(r_wj)) <<< 1);
        n_coef[7] = rnd((ext(r_wi) + ext(r_jk)) <<< 1);
        n_coef[8] = rnd(ext(r_ww) - ext(r_ii) - ext(r_jj) + ext(r_kk));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '{CoefOne, '0, '0, '0, CoefOne, '0, '0, '0, CoefOne};
        end else begin
            r_coef <= n_coef;
        end
    end

    assign o_coef = r_coef;

endmodule

/* design/qvr_rot_pipe.sv */
module qvr_rot_pipe #(
    parameter int VEC_WIDTH      = qvr_pkg::VecWidth,
    parameter int QUAT_FRAC_BITS = qvr_pkg::QuatFracBits
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_hold,
    input  logic signed [QUAT_FRAC_BITS+5:0] i_coef [qvr_pkg::NumCoef],
    qvr_vec_if.sink                          i_vec,
    qvr_rot_if.source                        o_rot
);
    import qvr_pkg::*;

    localparam int CW  = QUAT_FRAC_BITS + 6;   // coefficient
    localparam int PV  = CW + VEC_WIDTH;       // coefficient times component
    localparam int RW  = PV + 3;               // row sum plus rounding
    localparam int RNW = RW - QUAT_FRAC_BITS;  // rounded row sum

    localparam logic signed [RW-1:0] Half = RW'(1) << (QUAT_FRAC_BITS - 1);

    // Stage 1: input register
    logic                        r_v1, r_l1;
    logic signed [VEC_WIDTH-1:0] r_vec1 [NumAxis];
    // Stage 2: nine products
    logic                        r_v2, r_l2;
    logic signed [PV-1:0]        r_p2 [NumCoef];
    // Stage 3: rounded row sums
    logic                        r_v3, r_l3;
    logic signed [RNW-1:0]       r_r3 [NumAxis];
    logic signed [RW-1:0]        n_sum [NumAxis];
    // Stage 4: saturated output register
    logic                        r_v4, r_l4;
    logic signed [VEC_WIDTH-1:0] r_rot4 [NumAxis];

    logic en1, en2, en3, en4, accept;

    function automatic logic signed [VEC_WIDTH-1:0] sat(input logic signed [RNW-1:0] r);
        logic [RNW-VEC_WIDTH:0] top;
        top = r[RNW-1:VEC_WIDTH-1];
        if (top == '0 || top == '1) begin
            return r[VEC_WIDTH-1:0];
        end
        return r[RNW-1] ? {1'b1, {(VEC_WIDTH-1){1'b0}}} : {1'b0, {(VEC_WIDTH-1){1'b1}}};
    endfunction

    // Per-stage advance; bubbles collapse
    assign en4    = !r_v4 || o_rot.ready;
    assign en3    = !r_v3 || en4;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign i_vec.ready = en1 && !i_hold;
    assign accept = i_vec.valid && i_vec.ready;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= accept;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // Row sums, rounded half up
    always_comb begin
        for (int r = 0; r < NumAxis; r++) begin
            n_sum[r] = RW'(r_p2[3*r]) + RW'(r_p2[3*r+1]) + RW'(r_p2[3*r+2]) + Half;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (en1 && accept) begin
            r_vec1[0] <= i_vec.vec_x;
            r_vec1[1] <= i_vec.vec_y;
            r_vec1[2] <= i_vec.vec_z;
            r_l1      <= i_vec.last_in;
        end
        if (en2 && r_v1) begin
            for (int r = 0; r < NumAxis; r++) begin
                for (int c = 0; c < NumAxis; c++) begin
                    r_p2[3*r+c] <= i_coef[3*r+c] * r_vec1[c];
                end
            end
            r_l2 <= r_l1;
        end
        if (en3 && r_v2) begin
            for (int r = 0; r < NumAxis; r++) begin
                r_r3[r] <= n_sum[r][QUAT_FRAC_BITS +: RNW];
            end
            r_l3 <= r_l2;
        end
        if (en4 && r_v3) begin
            for (int r = 0; r < NumAxis; r++) begin
                r_rot4[r] <= sat(r_r3[r]);
            end
            r_l4 <= r_l3;
        end
    end

    assign o_rot.valid    = r_v4;
    assign o_rot.rot_x    = r_rot4[0];
    assign o_rot.rot_y    = r_rot4[1];
    assign o_rot.rot_z    = r_rot4[2];
    assign o_rot.last_out = r_l4;

endmodule

/* design/quaternion_vector_rotation_unit.sv */
// Quaternion rotation of 3D vectors.
//
// Configuration: write the quaternion (w, i, j, k, signed Q2.F) through
// i_cfg_we / i_cfg_idx / i_cfg_data, one register per write. The nine matrix
// coefficients follow through a product stage and a sum stage; i_vec.ready
// is held low in the write cycle and the cycle after it. Write only while
// no beat is in flight.
//
// Vector channel i_vec carries one vector per beat; o_rot returns the
// rotated, rounded and saturated vector with its last flag, in order.
// Each accepted beat goes through input register, multiply, row sum and
// saturate stages. Throughput: one beat per clock unless o_rot stalls or a
// write holds i_vec; nine multipliers work in parallel in the multiply stage.
//
// Reset loads the identity quaternion and matrix and empties the pipe.
// When o_rot stalls, each stage holds its beat and empty stages still fill,
// so up to four beats are taken before i_vec.ready drops.
module quaternion_vector_rotation_unit #(
    parameter int VEC_WIDTH      = qvr_pkg::VecWidth,
    parameter int QUAT_FRAC_BITS = qvr_pkg::QuatFracBits
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [qvr_pkg::CfgIdxWidth-1:0] i_cfg_idx,
    input  logic [QUAT_FRAC_BITS+1:0]       i_cfg_data,
    qvr_vec_if.sink                         i_vec,
    qvr_rot_if.source                       o_rot
);
    import qvr_pkg::*;

    localparam int CW = QUAT_FRAC_BITS + 6;
    localparam logic signed [CW-1:0] CoefOne = CW'(1) << QUAT_FRAC_BITS;

    logic signed [CW-1:0] w_coef [NumCoef];
    logic                 r_cfg_busy;

    // Busy in the cycle after the write cycle, while the matrix settles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_busy <= 1'b0;
        end else begin
            r_cfg_busy <= i_cfg_we;
        end
    end

    qvr_coef #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_coef (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coef     (w_coef)
    );

    qvr_rot_pipe #(
        .VEC_WIDTH      (VEC_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (i_cfg_we || r_cfg_busy),
        .i_coef  (w_coef),
        .i_vec   (i_vec),
        .o_rot   (o_rot)
    );

    // No beat is taken in a write cycle
    a_no_accept_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !(i_vec.valid && i_vec.ready))
        else $error("vector beat accepted during a config write");

    // Nor in the cycle after, while the matrix settles
    a_no_accept_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !(i_vec.valid && i_vec.ready))
        else $error("vector beat accepted before the matrix settled");

    // Reset leaves the identity matrix
    a_reset_identity: assert property (@(posedge i_clk)
        !i_rst_n |=> (w_coef[0] == CoefOne && w_coef[1] == '0 && w_coef[4] == CoefOne
                      && w_coef[8] == CoefOne && w_coef[5] == '0))
        else $error("coefficients not identity after reset");

endmodule

/* sim/qvr_tb_pkg.sv */
package qvr_tb_pkg;

    import qvr_pkg::*;

    localparam int QuatWidth = QuatFracBits + 2;

    localparam longint FracHalf = longint'(1) << (QuatFracBits - 1);
    localparam longint VecHigh  = (longint'(1) << (VecWidth - 1)) - 1;
    localparam longint VecLow   = -(longint'(1) << (VecWidth - 1));

    // One vector beat, used for both the input and the rotated result
    typedef struct packed {
        logic signed [VecWidth-1:0] x;
        logic signed [VecWidth-1:0] y;
        logic signed [VecWidth-1:0] z;
        logic                       last;
    } t_xyz_beat;

    // Predicts rotated vectors from the loaded quaternion and checks results
    class rotation_checker;

        longint    quat [4];
        longint    coef [9];
        t_xyz_beat pending_rotations [$];
        int        errors;

        function new();
            quat[CFG_QUAT_W] = longint'(1) << QuatFracBits;
            quat[CFG_QUAT_I] = 0;
            quat[CFG_QUAT_J] = 0;
            quat[CFG_QUAT_K] = 0;
            errors           = 0;
            rebuild_matrix();
        endfunction

        // Round from 2F (or F) fraction bits down by F, halves toward +inf
        function longint round_frac(longint s);
            return (s + FracHalf) >>> QuatFracBits;
        endfunction

        function void rebuild_matrix();
            longint w, i, j, k;
            longint ww, ii, jj, kk, wi, wj, wk, ij, ik, jk;
            w  = quat[CFG_QUAT_W];
            i  = quat[CFG_QUAT_I];
            j  = quat[CFG_QUAT_J];
            k  = quat[CFG_QUAT_K];
            ww = w * w;  ii = i * i;  jj = j * j;  kk = k * k;
            wi = w * i;  wj = w * j;  wk = w * k;
            ij = i * j;  ik = i * k;  jk = j * k;
            coef[0] = round_frac(ww + ii - jj - kk);
            coef[1] = round_frac(2 * (ij - wk));
            coef[2] = round_frac(2 * (wj + ik));
            coef[3] = round_frac(2 * (wk + ij));
            coef[4] = round_frac(ww - ii + jj - kk);
            coef[5] = round_frac(2 * (jk - wi));
            coef[6] = round_frac(2 * (ik - wj));
            coef[7] = round_frac(2 * (wi + jk));
            coef[8] = round_frac(ww - ii - jj + kk);
        endfunction

        function void write_quat(t_cfg_idx idx, logic [QuatWidth-1:0] data);
            quat[idx] = longint'($signed(data));
            rebuild_matrix();
        endfunction

        // Expected result of one accepted input beat
        function void note_vector(t_xyz_beat v);
            longint    comp [3];
            longint    acc;
            t_xyz_beat rot;
            logic [VecWidth-1:0] res [3];
            comp[0] = longint'($signed(v.x));
            comp[1] = longint'($signed(v.y));
            comp[2] = longint'($signed(v.z));
            for (int r = 0; r < 3; r++) begin
                acc = coef[3*r] * comp[0] + coef[3*r+1] * comp[1] + coef[3*r+2] * comp[2];
                acc = round_frac(acc);
                if (acc > VecHigh) acc = VecHigh;
                if (acc < VecLow)  acc = VecLow;
                res[r] = VecWidth'(acc);
            end
            rot.x    = res[0];
            rot.y    = res[1];
            rot.z    = res[2];
            rot.last = v.last;
            pending_rotations.push_back(rot);
        endfunction

        function void compare_field(string name, logic [VecWidth-1:0] exp_val,
                                    logic [VecWidth-1:0] act_val);
            if (act_val !== exp_val) begin
                $error("%s: expected %0d, actual %0d", name, $signed(exp_val),
                       $signed(act_val));
                errors++;
            end
        endfunction

        function void check_rotation(t_xyz_beat got);
            t_xyz_beat exp_rot;
            if (pending_rotations.size() == 0) begin
                $error("rotated beat with nothing pending: x %0d y %0d z %0d last %0d",
                       got.x, got.y, got.z, got.last);
                errors++;
                return;
            end
            exp_rot = pending_rotations.pop_front();
            compare_field("rot_x", exp_rot.x, got.x);
            compare_field("rot_y", exp_rot.y, got.y);
            compare_field("rot_z", exp_rot.z, got.z);
            compare_field("last_out", VecWidth'(exp_rot.last), VecWidth'(got.last));
        endfunction

        function bit is_drained();
            return pending_rotations.size() == 0;
        endfunction

    endclass

endpackage

/* sim/testbench.sv */
module testbench;

    import qvr_pkg::*;
    import qvr_tb_pkg::*;

    localparam int ClkPeriod     = 8;
    localparam int ResetCycles   = 11;
    localparam int HoldCycles    = 200;
    localparam int WatchdogLimit = 2000;
    localparam int PhaseItems    = 60;

    localparam logic [VecWidth-1:0] VecMax = {1'b0, {(VecWidth-1){1'b1}}};
    localparam logic [VecWidth-1:0] VecMin = {1'b1, {(VecWidth-1){1'b0}}};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    t_cfg_idx             cfg_idx;
    logic [QuatWidth-1:0] cfg_data;

    // Traffic shaping knobs
    bit tx_idle_en  = 1'b1;
    bit rx_stall_en = 1'b1;
    bit hold_req    = 1'b0;

    rotation_checker sb = new();

    qvr_vec_if vec_if ();
    qvr_rot_if rot_if ();

    quaternion_vector_rotation_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_vec      (vec_if),
        .o_rot      (rot_if)
    );

    always #(ClkPeriod / 2) i_clk = ~i_clk;

    // Result side: random stall bursts, plus one long hold-off on request
    initial begin : result_sink
        rot_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                rot_if.ready <= 1'b0;
                repeat (HoldCycles - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (rx_stall_en && $urandom_range(0, 5) == 0) begin
                rot_if.ready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge i_clk);
            end else begin
                rot_if.ready <= 1'b1;
            end
        end
    end

    // Check every rotated beat as it is taken
    always @(posedge i_clk) begin : result_monitor
        t_xyz_beat got;
        if (i_rst_n === 1'b1 && rot_if.valid === 1'b1 && rot_if.ready === 1'b1) begin
            got.x    = rot_if.rot_x;
            got.y    = rot_if.rot_y;
            got.z    = rot_if.rot_z;
            got.last = rot_if.last_out;
            sb.check_rotation(got);
        end
    end

    // Watchdog: too many cycles with no beat and no register write
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WatchdogLimit) begin
            @(posedge i_clk);
            if ((vec_if.valid === 1'b1 && vec_if.ready === 1'b1) ||
                (rot_if.valid === 1'b1 && rot_if.ready === 1'b1) ||
                cfg_we === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic t_xyz_beat mk_vec(logic [VecWidth-1:0] x, logic [VecWidth-1:0] y,
                                         logic [VecWidth-1:0] z, logic last);
        t_xyz_beat v;
        v.x    = x;
        v.y    = y;
        v.z    = z;
        v.last = last;
        return v;
    endfunction

    // Full-range values half the time, with extremes and small values mixed in
    function automatic logic [VecWidth-1:0] rand_comp();
        logic [VecWidth-1:0] c;
        case ($urandom_range(0, 7))
            0: c = VecMax;
            1: c = VecMin;
            2: c = VecWidth'(int'($urandom_range(0, 600)) - 300);
            3: c = VecWidth'(int'($urandom_range(0, 2)) - 1);
            default: c = VecWidth'($urandom);
        endcase
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat
    task automatic send_vec(t_xyz_beat v);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            vec_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        vec_if.valid   <= 1'b1;
        vec_if.vec_x   <= v.x;
        vec_if.vec_y   <= v.y;
        vec_if.vec_z   <= v.z;
        vec_if.last_in <= v.last;
        do @(posedge i_clk); while (vec_if.ready !== 1'b1);
        sb.note_vector(v);
        @(negedge i_clk);
    endtask

    // Stop offering beats and wait for every pending result
    task automatic drain();
        vec_if.valid <= 1'b0;
        do @(negedge i_clk); while (!sb.is_drained());
    endtask

    // Load selected quaternion registers while the pipe is empty
    task automatic reconfigure(input logic [QuatWidth-1:0] q [4], input bit [3:0] sel);
        t_cfg_idx idx;
        drain();
        for (int n = 0; n < 4; n++) begin
            if (sel[n]) begin
                idx = t_cfg_idx'(n);
                cfg_we   <= 1'b1;
                cfg_idx  <= idx;
                cfg_data <= q[n];
                @(posedge i_clk);
                sb.write_quat(idx, q[n]);
                @(negedge i_clk);
            end
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_reconfigure();
        logic [QuatWidth-1:0] q [4];
        bit   [3:0]           sel;
        int                   mode;
        mode = $urandom_range(0, 4);
        sel  = 4'b1111;
        for (int n = 0; n < 4; n++) begin
            case (mode)
                0, 3: q[n] = QuatWidth'($urandom);
                1: q[n] = QuatWidth'(int'($urandom_range(0, 18000)) - 9000);
                2: begin
                    case ($urandom_range(0, 4))
                        0: q[n] = 16'h7FFF;
                        1: q[n] = 16'h8000;
                        2: q[n] = 16'h4000;
                        3: q[n] = 16'hC000;
                        default: q[n] = 16'h0000;
                    endcase
                end
                default: q[n] = (n == 0) ? 16'h4000 : 16'h0000;
            endcase
        end
        // Rewrite of a single register must still rebuild the whole matrix
        if (mode == 3)
            sel = 4'b0001 << $urandom_range(0, 3);
        reconfigure(q, sel);
    endtask

    // Batches of vectors with last on the final one; some with random last
    task automatic run_batches(int n_items);
        int left;
        int blen;
        bit noisy;
        bit last;
        left = n_items;
        while (left > 0) begin
            blen  = $urandom_range(1, 8);
            if (blen > left) blen = left;
            noisy = ($urandom_range(0, 4) == 0);
            for (int b = 0; b < blen; b++) begin
                last = noisy ? 1'($urandom_range(0, 1)) : (b == blen - 1);
                send_vec(mk_vec(rand_comp(), rand_comp(), rand_comp(), last));
            end
            left -= blen;
        end
    endtask

    initial begin : stimulus
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_QUAT_W;
        cfg_data       = '0;
        vec_if.valid   = 1'b0;
        vec_if.vec_x   = '0;
        vec_if.vec_y   = '0;
        vec_if.vec_z   = '0;
        vec_if.last_in = 1'b0;
        repeat (ResetCycles) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Identity after reset, field extremes
        send_vec(mk_vec('0, '0, '0, 1'b0));
        send_vec(mk_vec(VecMax, VecMax, VecMax, 1'b1));
        send_vec(mk_vec(VecMin, VecMin, VecMin, 1'b0));
        send_vec(mk_vec(VecMax, VecMin, 24'd1, 1'b1));
        send_vec(mk_vec(-24'sd1, 24'd1, -24'sd1, 1'b0));

        // Quarter scale: products land on exact halves
        reconfigure('{16'h2000, 16'h0000, 16'h0000, 16'h0000}, 4'b1111);
        send_vec(mk_vec(24'd2, -24'sd2, 24'd6, 1'b0));
        send_vec(mk_vec(-24'sd6, 24'd1, -24'sd1, 1'b1));
        send_vec(mk_vec(24'd3, -24'sd3, 24'd0, 1'b0));

        // Ninety degrees about z
        reconfigure('{16'h2D41, 16'h0000, 16'h0000, 16'h2D41}, 4'b1111);
        send_vec(mk_vec(VecMax, VecMin, 24'd12345, 1'b0));
        send_vec(mk_vec(24'd1000, 24'd0, 24'd0, 1'b1));

        // Largest positive quaternion: heavy saturation
        reconfigure('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 4'b1111);
        send_vec(mk_vec(VecMax, VecMax, VecMax, 1'b1));
        send_vec(mk_vec(VecMin, VecMax, VecMin, 1'b0));
        send_vec(mk_vec(24'd1, -24'sd1, 24'd1, 1'b1));

        // Most negative quaternion
        reconfigure('{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 4'b1111);
        send_vec(mk_vec(VecMax, VecMin, VecMax, 1'b0));
        send_vec(mk_vec(VecMin, VecMin, VecMin, 1'b1));

        // Zero quaternion: everything maps to zero
        reconfigure('{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 4'b1111);
        send_vec(mk_vec(VecMax, VecMin, 24'd7, 1'b1));

        // Mixed extremes
        reconfigure('{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 4'b1111);
        send_vec(mk_vec(VecMin, VecMax, VecMax, 1'b0));
        send_vec(mk_vec(24'd5, 24'd6, 24'd7, 1'b1));

        // Random phases, each under a fresh quaternion
        for (int p = 0; p < 10; p++) begin
            random_reconfigure();
            if (p == 3)
                hold_req = 1'b1;
            if (p == 5) begin
                run_batches(PhaseItems / 2);
                drain();
                run_batches(PhaseItems / 2);
            end else begin
                run_batches(PhaseItems);
            end
        end

        // Closing stretch at full rate on both sides
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        random_reconfigure();
        run_batches(2 * PhaseItems);

        drain();
        repeat (8) @(negedge i_clk);
        if (!sb.is_drained()) begin
            $error("%0d rotated beats never arrived", sb.pending_rotations.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
design/qvr_pkg.sv
design/qvr_vec_if.sv
design/qvr_rot_if.sv
design/qvr_coef.sv
design/qvr_rot_pipe.sv
design/quaternion_vector_rotation_unit.sv
sim/qvr_tb_pkg.sv
sim/testbench.sv
